/* rtl/core/rgb_to_hsl_converter_unit_macros.svh */
// assertion macros for the rgb to hsl converter
// no dependencies; taken in by the top level with include
`ifndef RGB_TO_HSL_CONVERTER_UNIT_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RHSL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rhsl assertion failed");
`define RHSL_ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rhsl reset assertion failed");
`else
`define RHSL_ASSERT(lbl, clk, rst_n, prop)
`define RHSL_ASSERT_CLK(lbl, clk, prop)
`endif
`endif

/* rtl/core/rhsl_pkg.sv */
// types, constants and the division step of the rgb to hsl converter
// no dependencies
`default_nettype none

package rhsl_pkg;

    localparam int CB = 8;
    localparam int CW = CB + 3;
    localparam logic [CB-1:0] CM = {CB{1'b1}};

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        logic [CB-1:0] red;
        logic [CB-1:0] green;
        logic [CB-1:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [CB-1:0] hue_out;
        logic [CB-1:0] saturation_out;
        logic [CB-1:0] lightness_out;
    } t_pix_out;

    typedef struct packed {
        logic [CW-1:0] rem;
        logic [CB-1:0] lq;
        logic [CW-1:0] den;
    } t_div_lane;

    typedef struct packed {
        t_div_lane     sat;
        t_div_lane     hue;
        logic [CB-1:0] light;
    } t_div_req;

    // one restoring division step: shift in a dividend bit, shift out a quotient bit
    function automatic t_div_lane div_step(input t_div_lane l);
        logic [CW:0] trial;
        logic        q;
        t_div_lane   res;
        trial = {l.rem, l.lq[CB-1]};
        q = (trial >= {1'b0, l.den});
        res.den = l.den;
        res.rem = q ? CW'(trial - {1'b0, l.den}) : trial[CW-1:0];
        res.lq = {l.lq[CB-2:0], q};
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/rhsl_div.sv */
// pipelined divider for hue and saturation, one quotient bit per stage
// depends on rhsl_pkg
`default_nettype none

module rhsl_div
    import rhsl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_div_req i_req,
    output logic          o_stall,
    output logic          o_valid,
    output t_div_req      o_res,
    input  wire logic     i_stall
);

    logic     r_v  [CB];
    t_div_req r_st [CB];
    logic     take [CB];

    genvar k;
    generate
        for (k = 0; k < CB; k++) begin : g_stage
            t_div_req src;
            logic     src_v;
            t_div_req n_st;

            if (k == 0) begin : g_first
                assign src   = i_req;
                assign src_v = i_valid;
            end else begin : g_next
                assign src   = r_st[k-1];
                assign src_v = r_v[k-1];
            end

            if (k == CB - 1) begin : g_last
                assign take[k] = !r_v[k] || !i_stall;
            end else begin : g_mid
                assign take[k] = !r_v[k] || take[k+1];
            end

            always_comb begin
                n_st.sat   = div_step(src.sat);
                n_st.hue   = div_step(src.hue);
                n_st.light = src.light;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (take[k]) begin
                    r_v[k] <= src_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (take[k]) begin
                    r_st[k] <= n_st;
                end
            end
        end
    endgenerate

    assign o_stall = !take[0];
    assign o_valid = r_v[CB-1];
    assign o_res   = r_st[CB-1];

endmodule

`default_nettype wire

/* rtl/core/rgb_to_hsl_converter_unit.sv */
// top level of the rgb to hsl converter: range and sector stage, setup stage, divider
// depends on rhsl_pkg, rhsl_div and rgb_to_hsl_converter_unit_macros.svh
`default_nettype none
`include "rgb_to_hsl_converter_unit_macros.svh"

// Converts one 8-bit RGB pixel to 8-bit hue, saturation and lightness per request.
// A new request is taken every clock while o_stall is low; each request passes
// through registered stages in order: one stage finds max, min and the hue sector,
// one stage sets up both divisions, and eight stages of restoring division
// produce one quotient bit each for hue and saturation in parallel.
// Stalls hold each stage only while the stage after it is full, so bubbles close up.
// Equal components give hue 0, saturation 0 and lightness equal to red.
module rgb_to_hsl_converter_unit
    import rhsl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_pix_in i_pix,
    output logic         o_stall,
    output logic         o_valid,
    output t_pix_out     o_hsl,
    input  wire logic    i_stall
);

    typedef struct packed {
        logic [CB-1:0]      d;
        logic [CB:0]        sum;
        logic signed [CB:0] num;
        t_sector            sector;
    } t_stage_a;

    logic     r_va;
    t_stage_a r_a;
    t_stage_a n_a;
    logic     r_vb;
    t_div_req r_b;
    t_div_req n_b;
    logic     take_a;
    logic     take_b;
    logic     div_stall;
    t_div_req div_res;

    logic [CB-1:0] hi;
    logic [CB-1:0] lo;

    logic                 d_zero;
    logic signed [CB+3:0] off;
    logic signed [CB+3:0] x_pre;
    logic [CW-1:0]        d6;
    logic [CW-1:0]        x;
    logic [2*CB-1:0]      m_d;
    logic [CB:0]          sat_den;

    // range and sector
    always_comb begin
        hi = (i_pix.red > i_pix.green) ? i_pix.red : i_pix.green;
        hi = (hi > i_pix.blue) ? hi : i_pix.blue;
        lo = (i_pix.red < i_pix.green) ? i_pix.red : i_pix.green;
        lo = (lo < i_pix.blue) ? lo : i_pix.blue;
        n_a.d   = hi - lo;
        n_a.sum = {1'b0, hi} + {1'b0, lo};
        priority if (i_pix.red == hi) begin
            n_a.sector = SEC_RED;
            n_a.num    = $signed({1'b0, i_pix.green}) - $signed({1'b0, i_pix.blue});
        end else if (i_pix.green == hi) begin
            n_a.sector = SEC_GREEN;
            n_a.num    = $signed({1'b0, i_pix.blue}) - $signed({1'b0, i_pix.red});
        end else begin
            n_a.sector = SEC_BLUE;
            n_a.num    = $signed({1'b0, i_pix.red}) - $signed({1'b0, i_pix.green});
        end
    end

    // division setup
    always_comb begin
        d_zero = (r_a.d == '0);
        d6     = CW'({r_a.d, 2'b00}) + CW'({r_a.d, 1'b0});
        unique case (r_a.sector)
            SEC_RED:   off = '0;
            SEC_GREEN: off = $signed((CB+4)'({r_a.d, 1'b0}));
            SEC_BLUE:  off = $signed((CB+4)'({r_a.d, 2'b00}));
            default:   off = '0;
        endcase
        x_pre = off + (CB+4)'(r_a.num);
        if (x_pre < 0) begin
            x = CW'(x_pre + $signed({1'b0, d6}));
        end else begin
            x = x_pre[CW-1:0];
        end

        m_d     = {r_a.d, {CB{1'b0}}} - (2*CB)'(r_a.d);
        sat_den = r_a.sum[CB] ? ({CM, 1'b0} - r_a.sum) : r_a.sum;

        n_b.sat.rem = CW'(m_d[2*CB-1:CB]);
        n_b.sat.lq  = m_d[CB-1:0];
        n_b.sat.den = d_zero ? CW'(1) : CW'(sat_den);
        n_b.hue.rem = x;
        n_b.hue.lq  = '0;
        n_b.hue.den = d_zero ? CW'(1) : d6;
        n_b.light   = r_a.sum[CB:1];
    end

    assign take_b  = !r_vb || !div_stall;
    assign take_a  = !r_va || take_b;
    assign o_stall = !take_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (take_a) begin
                r_va <= i_valid;
            end
            if (take_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_a) begin
            r_a <= n_a;
        end
        if (take_b) begin
            r_b <= n_b;
        end
    end

    rhsl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vb),
        .i_req   (r_b),
        .o_stall (div_stall),
        .o_valid (o_valid),
        .o_res   (div_res),
        .i_stall (i_stall)
    );

    assign o_hsl.hue_out        = div_res.hue.lq;
    assign o_hsl.saturation_out = div_res.sat.lq;
    assign o_hsl.lightness_out  = div_res.light;

    `RHSL_ASSERT_CLK(a_rst_clears_out, i_clk, !i_rst_n |=> !o_valid)
    `RHSL_ASSERT(a_stall_means_full, i_clk, i_rst_n, o_stall |-> (r_va && r_vb && div_stall))
    `RHSL_ASSERT(a_div_stall_from_out, i_clk, i_rst_n, div_stall |-> (o_valid && i_stall))

endmodule

`default_nettype wire
